@@ hw/rtl/cdr_pkg.sv @@
// Shared constants, types and lookup functions for the calendar date register.
`default_nettype none
package cdr_pkg;

   localparam logic [22:0] JD_MIN      = 23'd1721426;
   localparam logic [22:0] JD_MAX      = 23'd5373484;
   localparam logic [3:0]  DEF_MONTH   = 4'd5;
   localparam logic [4:0]  DEF_DAY     = 5'd11;
   localparam logic [13:0] DEF_YEAR    = 14'd1959;
   localparam logic [13:0] YEAR_MIN    = 14'd1;
   localparam logic [13:0] YEAR_MAX    = 14'd9999;
   localparam logic [22:0] BETWEEN_MAX = 23'h3FFFFF;
   localparam logic [22:0] BETWEEN_MIN = 23'h400000;

   // request commands
   localparam logic [1:0] CMD_LOAD_DATE = 2'd0;
   localparam logic [1:0] CMD_LOAD_JDN  = 2'd1;
   localparam logic [1:0] CMD_SHIFT     = 2'd2;
   localparam logic [1:0] CMD_BETWEEN   = 2'd3;

   localparam int DIV_X_W = 30;
   localparam int DIV_D_W = 21;

   typedef enum logic [2:0] {
      DIV_7,
      DIV_11,
      DIV_80,
      DIV_100,
      DIV_2447,
      DIV_146097,
      DIV_1461001
   } div_sel_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_X_W-1:0]   x;
      div_sel_type          sel;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_X_W-1:0]   q;
      logic [DIV_D_W-1:0]   r;
   } div_res_type;

   // divisor value
   function automatic logic [DIV_D_W-1:0] div_const(input div_sel_type sel);
      logic [DIV_D_W-1:0] d;
      unique case (sel)
         DIV_7:       d = 21'd7;
         DIV_11:      d = 21'd11;
         DIV_80:      d = 21'd80;
         DIV_100:     d = 21'd100;
         DIV_2447:    d = 21'd2447;
         DIV_146097:  d = 21'd146097;
         DIV_1461001: d = 21'd1461001;
         default:     d = 21'd7;
      endcase
      return d;
   endfunction

   // floor(2^shift / divisor); the dividend stays below 2^shift
   function automatic logic [DIV_D_W-1:0] div_recip(input div_sel_type sel);
      logic [DIV_D_W-1:0] k;
      unique case (sel)
         DIV_7:       k = 21'd1198372;
         DIV_11:      k = 21'd11;
         DIV_80:      k = 21'd3276;
         DIV_100:     k = 21'd327;
         DIV_2447:    k = 21'd107;
         DIV_146097:  k = 21'd229;
         DIV_1461001: k = 21'd734;
         default:     k = 21'd1198372;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] div_shift(input div_sel_type sel);
      logic [4:0] s;
      unique case (sel)
         DIV_7:       s = 5'd23;
         DIV_11:      s = 5'd7;
         DIV_80:      s = 5'd18;
         DIV_100:     s = 5'd15;
         DIV_2447:    s = 5'd18;
         DIV_146097:  s = 5'd25;
         DIV_1461001: s = 5'd30;
         default:     s = 5'd23;
      endcase
      return s;
   endfunction

   // month term 367 * (m - 2 - 12t) / 12 of the day number formula
   function automatic logic [8:0] month_term(input logic [3:0] m);
      logic [8:0] v;
      case (m)
         4'd0:    v = 9'd305;
         4'd1:    v = 9'd336;
         4'd2:    v = 9'd367;
         4'd3:    v = 9'd30;
         4'd4:    v = 9'd61;
         4'd5:    v = 9'd91;
         4'd6:    v = 9'd122;
         4'd7:    v = 9'd152;
         4'd8:    v = 9'd183;
         4'd9:    v = 9'd214;
         4'd10:   v = 9'd244;
         4'd11:   v = 9'd275;
         4'd12:   v = 9'd305;
         4'd13:   v = 9'd336;
         4'd14:   v = 9'd367;
         default: v = 9'd397;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/cdr_if.sv @@
// Request and response channel interfaces of the calendar date register.
`default_nettype none
interface cdr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [3:0]         in_month;
   logic [4:0]         in_day;
   logic [13:0]        in_year;
   logic [22:0]        julian_in;
   logic signed [22:0] day_offset;

   modport source (output valid, cmd, in_month, in_day, in_year, julian_in, day_offset,
                   input ready);
   modport sink (input valid, cmd, in_month, in_day, in_year, julian_in, day_offset,
                 output ready);
endinterface

interface cdr_rsp_if;
   logic               valid;
   logic               ready;
   logic               accepted;
   logic [3:0]         cur_month;
   logic [4:0]         cur_day;
   logic [13:0]        cur_year;
   logic [22:0]        julian_day;
   logic [2:0]         weekday;
   logic [8:0]         day_of_year;
   logic signed [22:0] days_between;

   modport source (output valid, accepted, cur_month, cur_day, cur_year, julian_day,
                   weekday, day_of_year, days_between, input ready);
   modport sink (input valid, accepted, cur_month, cur_day, cur_year, julian_day,
                 weekday, day_of_year, days_between, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/cdr_div.sv @@
// Shared constant divider: reciprocal multiply, multiply back, one correction step.
`default_nettype none
module cdr_div import cdr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_res_type res
);

   typedef enum logic [1:0] {D_IDLE, D_MULK, D_MULD, D_FIX} state_type;

   state_type            state_ff;
   logic [DIV_X_W-1:0]   x_ff;
   div_sel_type          sel_ff;
   logic [50:0]          p_ff;
   logic [DIV_X_W-1:0]   q0_ff;
   logic [DIV_X_W-1:0]   m_ff;
   logic                 done_ff;
   logic [DIV_X_W-1:0]   q_ff;
   logic [DIV_D_W-1:0]   r_ff;

   logic [DIV_X_W-1:0]   q0_in;
   logic [DIV_X_W-1:0]   mul_a;
   logic [DIV_D_W-1:0]   mul_b;
   logic [50:0]          prod;
   logic [DIV_X_W:0]     r0;
   logic [DIV_D_W-1:0]   dval;

   assign dval  = div_const(sel_ff);
   assign q0_in = DIV_X_W'(p_ff >> div_shift(sel_ff));
   assign mul_a = (state_ff == D_MULK) ? x_ff : q0_in;
   assign mul_b = (state_ff == D_MULK) ? div_recip(sel_ff) : dval;
   assign prod  = {21'b0, mul_a} * {30'b0, mul_b};
   assign r0    = {1'b0, x_ff} - {1'b0, m_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == D_FIX);
         unique case (state_ff)
            D_IDLE: begin
               if (req.start) begin
                  x_ff     <= req.x;
                  sel_ff   <= req.sel;
                  state_ff <= D_MULK;
               end
            end
            D_MULK: begin
               p_ff     <= prod;
               state_ff <= D_MULD;
            end
            D_MULD: begin
               q0_ff    <= q0_in;
               m_ff     <= prod[DIV_X_W-1:0];
               state_ff <= D_FIX;
            end
            D_FIX: begin
               // estimate is low by at most one
               if (r0 >= {10'b0, dval}) begin
                  q_ff <= q0_ff + 30'd1;
                  r_ff <= DIV_D_W'(r0 - {10'b0, dval});
               end else begin
                  q_ff <= q0_ff;
                  r_ff <= r0[DIV_D_W-1:0];
               end
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign res.done = done_ff;
   assign res.q    = q_ff;
   assign res.r    = r_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> state_ff == D_IDLE) else $error("divider started while busy");
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      req.start |=> state_ff == D_MULK) else $error("divider did not launch");
   a_fix_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == D_FIX |=> res.done) else $error("divider result missing");

endmodule
`default_nettype wire

@@ hw/rtl/calendar_date_register.sv @@
// Calendar date register: stored Gregorian date with Julian day number conversions.
// Each request uses the shared divider for up to 10 divisions by a constant.
// Throughput: one request at a time; ready stays low until the response is registered.
// A response waiting at the output does not block the next request.
// Reset (synchronous) stores 11 May 1959 and empties the response register.
`default_nettype none
module calendar_date_register import cdr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   cdr_req_if.sink   req_if,
   cdr_rsp_if.source rsp_if
);

   typedef enum logic [4:0] {
      S_IDLE, S_TJ_GO, S_TJ_WT, S_FJ_N_GO, S_FJ_N_WT, S_FJ_I_GO, S_FJ_I_WT,
      S_FJ_J_GO, S_FJ_J_WT, S_FJ_K_GO, S_FJ_K_WT, S_FJ_L_GO, S_FJ_L_WT,
      S_NEXT, S_MOD_GO, S_MOD_WT, S_RESP
   } state_type;

   typedef enum logic [3:0] {
      P_LD_TJ, P_LD_FJ, P_STORE, P_SH_TJ, P_BT_TJ0, P_BT_TJ1, P_BT_FJ,
      P_OUT_TJ, P_OUT_ST
   } phase_type;

   state_type   state_ff;
   phase_type   phase_ff;

   logic [3:0]  im_ff;
   logic [4:0]  id_ff;
   logic [13:0] iy_ff;
   logic [22:0] off_ff;

   logic [3:0]  date_month_ff;
   logic [4:0]  date_day_ff;
   logic [13:0] date_year_ff;

   logic [3:0]  tm_ff;
   logic [4:0]  td_ff;
   logic [13:0] ty_ff;
   logic [22:0] tj_ff;

   logic [22:0] fj_ff;
   logic [7:0]  fn_ff;
   logic [17:0] fl_ff;
   logic [8:0]  fi_ff;
   logic [10:0] fl2_ff;
   logic [6:0]  fjj_ff;
   logic [3:0]  fm_ff;
   logic [4:0]  fd_ff;
   logic [14:0] fy_ff;

   logic [22:0] jd0_ff;
   logic [22:0] jdo_ff;
   logic [8:0]  doy_ff;
   logic [2:0]  wd_ff;
   logic [22:0] between_ff;
   logic        acc_ff;

   logic        rsp_valid_ff;
   logic        rsp_acc_ff;
   logic [3:0]  rsp_month_ff;
   logic [4:0]  rsp_day_ff;
   logic [13:0] rsp_year_ff;
   logic [22:0] rsp_jd_ff;
   logic [2:0]  rsp_wd_ff;
   logic [8:0]  rsp_doy_ff;
   logic [22:0] rsp_between_ff;

   div_req_type div_req;
   div_res_type div_res;

   cdr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .res   (div_res)
   );

   // day number of (td, tm, ty)
   logic        tneg;
   logic [14:0] ya;
   logic [14:0] yc;
   logic [25:0] ya_mul;
   logic [7:0]  cq;
   logic [9:0]  c3;
   logic [24:0] tj_sum;

   assign tneg   = (tm_ff <= 4'd2);
   assign ya     = {1'b0, ty_ff} + 15'd4800 - {14'b0, tneg};
   assign yc     = {1'b0, ty_ff} + 15'd4900 - {14'b0, tneg};
   assign ya_mul = {11'b0, ya} * 26'd1461;
   assign cq     = div_res.q[7:0];
   assign c3     = {2'b0, cq} + {1'b0, cq, 1'b0};
   assign tj_sum = {20'b0, td_ff} + {2'b0, ya_mul[24:2]} + {16'b0, month_term(tm_ff)}
                 - {17'b0, c3[9:2]} - 25'd32075;

   // date of day number fj
   logic [23:0] l0;
   logic [25:0] n_mul;
   logic [25:0] n_sum;
   logic [25:0] l1_full;
   logic [18:0] fl_p1;
   logic [30:0] i_mul;
   logic [19:0] i_m;
   logic [19:0] l2_full;
   logic [17:0] j_mul;
   logic [18:0] k_mul;
   logic [10:0] fd_full;
   logic [2:0]  lq;
   logic [7:0]  fm_full;
   logic [15:0] fy_full;

   assign l0      = {1'b0, fj_ff} + 24'd68569;
   assign n_mul   = {18'b0, div_res.q[7:0]} * 26'd146097;
   assign n_sum   = n_mul + 26'd3;
   assign l1_full = {2'b0, l0} - {2'b0, n_sum[25:2]};
   assign fl_p1   = {1'b0, fl_ff} + 19'd1;
   assign i_mul   = {12'b0, fl_p1} * 31'd4000;
   assign i_m     = {11'b0, div_res.q[8:0]} * 20'd1461;
   assign l2_full = {2'b0, fl_ff} - {2'b0, i_m[19:2]} + 20'd31;
   assign j_mul   = {7'b0, fl2_ff} * 18'd80;
   assign k_mul   = {12'b0, fjj_ff} * 19'd2447;
   assign fd_full = fl2_ff - div_res.q[10:0];
   assign lq      = div_res.q[2:0];
   assign fm_full = {1'b0, fjj_ff} + 8'd2 - ({5'b0, lq} * 8'd12);
   assign fy_full = ({8'b0, fn_ff} - 16'd49) * 16'd100 + {7'b0, fi_ff} + {13'b0, lq};

   // shift and difference
   logic [24:0] s_full;
   logic        s_ok;
   logic [23:0] diff;
   logic [22:0] diff_sat;
   logic        iy_ok;
   logic        match;
   logic        req_fire;
   logic        load_rsp;

   assign s_full   = {2'b0, tj_ff} + {{2{off_ff[22]}}, off_ff};
   assign s_ok     = !s_full[24] && (s_full[23:0] >= {1'b0, JD_MIN})
                     && (s_full[23:0] <= {1'b0, JD_MAX});
   assign diff     = {1'b0, tj_ff} - {1'b0, jd0_ff};
   assign diff_sat = (diff[23] == diff[22]) ? diff[22:0]
                   : (diff[23] ? BETWEEN_MIN : BETWEEN_MAX);
   assign iy_ok    = (iy_ff >= YEAR_MIN) && (iy_ff <= YEAR_MAX);
   assign match    = (fm_ff == im_ff) && (fd_ff == id_ff) && (fy_ff == {1'b0, iy_ff});
   assign req_fire = req_if.valid && req_if.ready;
   assign load_rsp = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      div_req.start = 1'b1;
      div_req.x     = '0;
      div_req.sel   = DIV_7;
      case (state_ff)
         S_TJ_GO: begin
            div_req.x   = {15'b0, yc};
            div_req.sel = DIV_100;
         end
         S_FJ_N_GO: begin
            div_req.x   = {4'b0, l0, 2'b00};
            div_req.sel = DIV_146097;
         end
         S_FJ_I_GO: begin
            div_req.x   = i_mul[29:0];
            div_req.sel = DIV_1461001;
         end
         S_FJ_J_GO: begin
            div_req.x   = {12'b0, j_mul};
            div_req.sel = DIV_2447;
         end
         S_FJ_K_GO: begin
            div_req.x   = {11'b0, k_mul};
            div_req.sel = DIV_80;
         end
         S_FJ_L_GO: begin
            div_req.x   = {23'b0, fjj_ff};
            div_req.sel = DIV_11;
         end
         S_MOD_GO: begin
            div_req.x   = {7'b0, jdo_ff};
            div_req.sel = DIV_7;
         end
         default: div_req.start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         date_month_ff <= DEF_MONTH;
         date_day_ff   <= DEF_DAY;
         date_year_ff  <= DEF_YEAR;
      end else begin
         if (rsp_valid_ff && rsp_if.ready && !load_rsp) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  im_ff      <= req_if.in_month;
                  id_ff      <= req_if.in_day;
                  iy_ff      <= req_if.in_year;
                  off_ff     <= req_if.day_offset;
                  between_ff <= '0;
                  acc_ff     <= 1'b0;
                  unique case (req_if.cmd)
                     CMD_LOAD_DATE: begin
                        if ((req_if.in_year >= YEAR_MIN) && (req_if.in_year <= YEAR_MAX)) begin
                           tm_ff    <= req_if.in_month;
                           td_ff    <= req_if.in_day;
                           ty_ff    <= req_if.in_year;
                           phase_ff <= P_LD_TJ;
                        end else begin
                           date_month_ff <= DEF_MONTH;
                           date_day_ff   <= DEF_DAY;
                           date_year_ff  <= DEF_YEAR;
                           tm_ff    <= DEF_MONTH;
                           td_ff    <= DEF_DAY;
                           ty_ff    <= DEF_YEAR;
                           phase_ff <= P_OUT_TJ;
                        end
                        state_ff <= S_TJ_GO;
                     end
                     CMD_LOAD_JDN: begin
                        tm_ff <= date_month_ff;
                        td_ff <= date_day_ff;
                        ty_ff <= date_year_ff;
                        if ((req_if.julian_in >= JD_MIN) && (req_if.julian_in <= JD_MAX)) begin
                           fj_ff    <= req_if.julian_in;
                           phase_ff <= P_STORE;
                           state_ff <= S_FJ_N_GO;
                        end else begin
                           phase_ff <= P_OUT_TJ;
                           state_ff <= S_TJ_GO;
                        end
                     end
                     CMD_SHIFT: begin
                        tm_ff    <= date_month_ff;
                        td_ff    <= date_day_ff;
                        ty_ff    <= date_year_ff;
                        phase_ff <= P_SH_TJ;
                        state_ff <= S_TJ_GO;
                     end
                     default: begin
                        tm_ff    <= date_month_ff;
                        td_ff    <= date_day_ff;
                        ty_ff    <= date_year_ff;
                        phase_ff <= P_BT_TJ0;
                        state_ff <= S_TJ_GO;
                     end
                  endcase
               end
            end
            S_TJ_GO:   state_ff <= S_TJ_WT;
            S_TJ_WT: begin
               if (div_res.done) begin
                  tj_ff    <= tj_sum[22:0];
                  state_ff <= S_NEXT;
               end
            end
            S_FJ_N_GO: state_ff <= S_FJ_N_WT;
            S_FJ_N_WT: begin
               if (div_res.done) begin
                  fn_ff    <= div_res.q[7:0];
                  fl_ff    <= l1_full[17:0];
                  state_ff <= S_FJ_I_GO;
               end
            end
            S_FJ_I_GO: state_ff <= S_FJ_I_WT;
            S_FJ_I_WT: begin
               if (div_res.done) begin
                  fi_ff    <= div_res.q[8:0];
                  fl2_ff   <= l2_full[10:0];
                  state_ff <= S_FJ_J_GO;
               end
            end
            S_FJ_J_GO: state_ff <= S_FJ_J_WT;
            S_FJ_J_WT: begin
               if (div_res.done) begin
                  fjj_ff   <= div_res.q[6:0];
                  state_ff <= S_FJ_K_GO;
               end
            end
            S_FJ_K_GO: state_ff <= S_FJ_K_WT;
            S_FJ_K_WT: begin
               if (div_res.done) begin
                  fd_ff    <= fd_full[4:0];
                  state_ff <= S_FJ_L_GO;
               end
            end
            S_FJ_L_GO: state_ff <= S_FJ_L_WT;
            S_FJ_L_WT: begin
               if (div_res.done) begin
                  fm_ff    <= fm_full[3:0];
                  fy_ff    <= fy_full[14:0];
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               unique case (phase_ff)
                  P_LD_TJ: begin
                     fj_ff    <= tj_ff;
                     phase_ff <= P_LD_FJ;
                     state_ff <= S_FJ_N_GO;
                  end
                  P_LD_FJ: begin
                     // keep the date only if the round trip returns it unchanged
                     if (match) begin
                        date_month_ff <= im_ff;
                        date_day_ff   <= id_ff;
                        date_year_ff  <= iy_ff;
                        tm_ff  <= im_ff;
                        td_ff  <= id_ff;
                        ty_ff  <= iy_ff;
                        acc_ff <= 1'b1;
                     end else begin
                        date_month_ff <= DEF_MONTH;
                        date_day_ff   <= DEF_DAY;
                        date_year_ff  <= DEF_YEAR;
                        tm_ff  <= DEF_MONTH;
                        td_ff  <= DEF_DAY;
                        ty_ff  <= DEF_YEAR;
                     end
                     phase_ff <= P_OUT_TJ;
                     state_ff <= S_TJ_GO;
                  end
                  P_STORE: begin
                     date_month_ff <= fm_ff;
                     date_day_ff   <= fd_ff;
                     date_year_ff  <= fy_ff[13:0];
                     tm_ff    <= fm_ff;
                     td_ff    <= fd_ff;
                     ty_ff    <= fy_ff[13:0];
                     acc_ff   <= 1'b1;
                     phase_ff <= P_OUT_TJ;
                     state_ff <= S_TJ_GO;
                  end
                  P_SH_TJ: begin
                     if (s_ok) begin
                        fj_ff    <= s_full[22:0];
                        phase_ff <= P_STORE;
                        state_ff <= S_FJ_N_GO;
                     end else begin
                        phase_ff <= P_OUT_TJ;
                        state_ff <= S_TJ_GO;
                     end
                  end
                  P_BT_TJ0: begin
                     jd0_ff   <= tj_ff;
                     tm_ff    <= im_ff;
                     td_ff    <= id_ff;
                     ty_ff    <= iy_ff;
                     phase_ff <= P_BT_TJ1;
                     state_ff <= S_TJ_GO;
                  end
                  P_BT_TJ1: begin
                     between_ff <= diff_sat;
                     tm_ff      <= date_month_ff;
                     td_ff      <= date_day_ff;
                     ty_ff      <= date_year_ff;
                     if (iy_ok) begin
                        fj_ff    <= tj_ff;
                        phase_ff <= P_BT_FJ;
                        state_ff <= S_FJ_N_GO;
                     end else begin
                        phase_ff <= P_OUT_TJ;
                        state_ff <= S_TJ_GO;
                     end
                  end
                  P_BT_FJ: begin
                     acc_ff   <= match;
                     phase_ff <= P_OUT_TJ;
                     state_ff <= S_TJ_GO;
                  end
                  P_OUT_TJ: begin
                     // next: day number of the first of January
                     jdo_ff   <= tj_ff;
                     tm_ff    <= 4'd1;
                     td_ff    <= 5'd1;
                     phase_ff <= P_OUT_ST;
                     state_ff <= S_TJ_GO;
                  end
                  P_OUT_ST: begin
                     doy_ff   <= 9'(jdo_ff - tj_ff + 23'd1);
                     state_ff <= S_MOD_GO;
                  end
                  default: state_ff <= S_MOD_GO;
               endcase
            end
            S_MOD_GO: state_ff <= S_MOD_WT;
            S_MOD_WT: begin
               if (div_res.done) begin
                  wd_ff    <= div_res.r[2:0];
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (load_rsp) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_acc_ff     <= acc_ff;
                  rsp_month_ff   <= date_month_ff;
                  rsp_day_ff     <= date_day_ff;
                  rsp_year_ff    <= date_year_ff;
                  rsp_jd_ff      <= jdo_ff;
                  rsp_wd_ff      <= wd_ff;
                  rsp_doy_ff     <= doy_ff;
                  rsp_between_ff <= between_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_if.ready        = (state_ff == S_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.accepted     = rsp_acc_ff;
   assign rsp_if.cur_month    = rsp_month_ff;
   assign rsp_if.cur_day      = rsp_day_ff;
   assign rsp_if.cur_year     = rsp_year_ff;
   assign rsp_if.julian_day   = rsp_jd_ff;
   assign rsp_if.weekday      = rsp_wd_ff;
   assign rsp_if.day_of_year  = rsp_doy_ff;
   assign rsp_if.days_between = rsp_between_ff;

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_if.ready) else $error("ready while a request is in work");
   a_year_range: assert property (@(posedge clock) disable iff (reset)
      (date_year_ff >= YEAR_MIN) && (date_year_ff <= YEAR_MAX))
      else $error("stored year out of range");
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (date_month_ff >= 4'd1) && (date_month_ff <= 4'd12) && (date_day_ff >= 5'd1))
      else $error("stored month or day out of range");
   a_div_waited: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == S_TJ_WT || state_ff == S_FJ_N_WT ||
                        state_ff == S_FJ_I_WT || state_ff == S_FJ_J_WT ||
                        state_ff == S_FJ_K_WT || state_ff == S_FJ_L_WT ||
                        state_ff == S_MOD_WT))
      else $error("divider result arrived outside a wait state");

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the calendar date register with a built-in day number predictor.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import cdr_pkg::*;

   typedef struct {
      logic [1:0]         cmd;
      logic [3:0]         in_month;
      logic [4:0]         in_day;
      logic [13:0]        in_year;
      logic [22:0]        julian_in;
      logic signed [22:0] day_offset;
   } date_request_type;

   typedef struct {
      logic               accepted;
      logic [3:0]         cur_month;
      logic [4:0]         cur_day;
      logic [13:0]        cur_year;
      logic [22:0]        julian_day;
      logic [2:0]         weekday;
      logic [8:0]         day_of_year;
      logic signed [22:0] days_between;
   } date_response_type;

   localparam int         STALL_START   = 8000;
   localparam int         STALL_CYCLES  = 400;
   localparam int         WATCHDOG_MAX  = 3000;

   logic clock;
   logic reset;
   cdr_req_if req_if ();
   cdr_rsp_if rsp_if ();

   calendar_date_register i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   date_request_type  pending_requests[$];
   date_response_type expected_responses[$];
   int  errors = 0;
   int  cycle_count = 0;
   int  quiet_cycles = 0;
   int  stall_left = 0;
   logic request_taken = 1'b0;

   longint held_month, held_day, held_year;

   function automatic longint julian_of_date(longint d, longint m, longint y);
      longint t;
      t = (m - 14) / 12;
      return d - 32075 + 1461 * (y + 4800 + t) / 4 + 367 * (m - 2 - t * 12) / 12
             - 3 * ((y + 4900 + t) / 100) / 4;
   endfunction

   function automatic void date_of_julian(input longint jd, output longint m,
                                          output longint d, output longint y);
      longint l, n, i, j, k;
      l = jd + 68569;
      n = 4 * l / 146097;
      l = l - (146097 * n + 3) / 4;
      i = 4000 * (l + 1) / 1461001;
      l = l - 1461 * i / 4 + 31;
      j = 80 * l / 2447;
      k = l - 2447 * j / 80;
      l = j / 11;
      j = j + 2 - 12 * l;
      y = 100 * (n - 49) + i + l;
      m = j;
      d = k;
   endfunction

   function automatic bit calendar_valid(longint m, longint d, longint y);
      longint m1, d1, y1;
      if (y < 1 || y > 9999) return 1'b0;
      date_of_julian(julian_of_date(d, m, y), m1, d1, y1);
      return m1 == m && d1 == d && y1 == y;
   endfunction

   function automatic bit store_julian(longint jd);
      if (jd < longint'(JD_MIN) || jd > longint'(JD_MAX)) return 1'b0;
      date_of_julian(jd, held_month, held_day, held_year);
      return 1'b1;
   endfunction

   function automatic date_response_type predict_response(date_request_type r);
      date_response_type p;
      longint m, d, y, jd, between;
      bit ok;
      m = longint'(r.in_month);
      d = longint'(r.in_day);
      y = longint'(r.in_year);
      between = 0;
      ok = 1'b0;
      case (r.cmd)
         CMD_LOAD_DATE: begin
            ok = calendar_valid(m, d, y);
            if (ok) begin
               held_month = m; held_day = d; held_year = y;
            end else begin
               held_month = longint'(DEF_MONTH);
               held_day = longint'(DEF_DAY);
               held_year = longint'(DEF_YEAR);
            end
         end
         CMD_LOAD_JDN: ok = store_julian(longint'(r.julian_in));
         CMD_SHIFT: begin
            jd = julian_of_date(held_day, held_month, held_year);
            ok = store_julian(jd + longint'(r.day_offset));
         end
         default: begin
            jd = julian_of_date(held_day, held_month, held_year);
            between = julian_of_date(d, m, y) - jd;
            if (between > 4194303) between = 4194303;
            if (between < -4194304) between = -4194304;
            ok = calendar_valid(m, d, y);
         end
      endcase
      jd = julian_of_date(held_day, held_month, held_year);
      p.accepted     = ok;
      p.cur_month    = held_month[3:0];
      p.cur_day      = held_day[4:0];
      p.cur_year     = held_year[13:0];
      p.julian_day   = jd[22:0];
      p.weekday      = 3'(jd % 7);
      p.day_of_year  = 9'(jd - julian_of_date(1, 1, held_year) + 1);
      p.days_between = between[22:0];
      return p;
   endfunction

   task automatic check_field(string name, longint exp_val, longint act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         errors++;
      end
   endtask

   function automatic date_request_type make_request(logic [1:0] cmd, int m, int d, int y,
                                                     int jin, int off);
      date_request_type r;
      r.cmd = cmd; r.in_month = 4'(m); r.in_day = 5'(d); r.in_year = 14'(y);
      r.julian_in = 23'(jin); r.day_offset = 23'(off);
      return r;
   endfunction

   function automatic date_request_type random_request();
      date_request_type r;
      int roll;
      roll = $urandom_range(0, 99);
      r.cmd = CMD_LOAD_DATE;
      r.in_month = 4'($urandom); r.in_day = 5'($urandom); r.in_year = 14'($urandom);
      r.julian_in = 23'($urandom); r.day_offset = 23'($urandom);
      if (roll < 30 || (roll >= 85 && roll < 95)) begin
         // mostly well-formed dates, some with day 28..31 near month ends
         r.in_month = 4'($urandom_range(1, 12));
         r.in_day = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(28, 31))
                                                : 5'($urandom_range(1, 28));
         r.in_year = ($urandom_range(0, 1) == 0) ? 14'($urandom_range(1, 9999))
                                                 : 14'($urandom_range(1895, 2105));
      end
      if (roll >= 40 && roll < 55) begin
         r.cmd = CMD_LOAD_JDN;
         if ($urandom_range(0, 9) != 0)
            r.julian_in = 23'($urandom_range(int'(JD_MIN), int'(JD_MAX)));
      end else if (roll >= 55 && roll < 85) begin
         r.cmd = CMD_SHIFT;
         if ($urandom_range(0, 9) != 0)
            r.day_offset = 23'(int'($urandom_range(0, 4000)) - 2000);
         else if ($urandom_range(0, 1) == 0)
            r.day_offset = 23'(int'($urandom_range(0, 7000000)) - 3500000);
      end else if (roll >= 85) begin
         r.cmd = CMD_BETWEEN;
      end
      return r;
   endfunction

   // stimulus and end of run
   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.cmd = '0; req_if.in_month = '0; req_if.in_day = '0; req_if.in_year = '0;
      req_if.julian_in = '0; req_if.day_offset = '0;
      rsp_if.ready = 1'b0;
      held_month = longint'(DEF_MONTH);
      held_day = longint'(DEF_DAY);
      held_year = longint'(DEF_YEAR);

      pending_requests.push_back(make_request(CMD_BETWEEN, 5, 11, 1959, 0, 0));
      pending_requests.push_back(make_request(CMD_LOAD_DATE, 1, 1, 1, 0, 0));
      pending_requests.push_back(make_request(CMD_SHIFT, 0, 0, 0, 0, -1));
      pending_requests.push_back(make_request(CMD_LOAD_DATE, 12, 31, 9999, 0, 0));
      pending_requests.push_back(make_request(CMD_SHIFT, 0, 0, 0, 0, 1));
      pending_requests.push_back(make_request(CMD_BETWEEN, 1, 1, 1, 0, 0));
      pending_requests.push_back(make_request(CMD_LOAD_DATE, 2, 29, 2000, 0, 0));
      pending_requests.push_back(make_request(CMD_LOAD_DATE, 2, 29, 1900, 0, 0));
      pending_requests.push_back(make_request(CMD_LOAD_DATE, 0, 10, 2020, 0, 0));
      pending_requests.push_back(make_request(CMD_LOAD_DATE, 15, 31, 16383, 0, 0));
      pending_requests.push_back(make_request(CMD_LOAD_DATE, 4, 0, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_LOAD_JDN, 0, 0, 0, int'(JD_MIN), 0));
      pending_requests.push_back(make_request(CMD_LOAD_JDN, 0, 0, 0, int'(JD_MAX), 0));
      pending_requests.push_back(make_request(CMD_LOAD_JDN, 0, 0, 0, int'(JD_MAX) + 1, 0));
      pending_requests.push_back(make_request(CMD_LOAD_JDN, 0, 0, 0, int'(JD_MIN) - 1, 0));
      pending_requests.push_back(make_request(CMD_LOAD_JDN, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_LOAD_JDN, 0, 0, 0, 8388607, 0));
      pending_requests.push_back(make_request(CMD_SHIFT, 0, 0, 0, 0, 4194303));
      pending_requests.push_back(make_request(CMD_SHIFT, 0, 0, 0, 0, -4194304));
      pending_requests.push_back(make_request(CMD_SHIFT, 0, 0, 0, 0, 365));
      pending_requests.push_back(make_request(CMD_BETWEEN, 15, 31, 16383, 0, 0));
      pending_requests.push_back(make_request(CMD_BETWEEN, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_BETWEEN, 12, 31, 9999, 0, 0));
      repeat (500) pending_requests.push_back(random_request());

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_requests.size() != 0 || req_if.valid
                 || expected_responses.size() != 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_responses.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   function automatic bit idle_now();
      if (cycle_count >= 2000 && cycle_count < 5000) return 1'b0;
      return $urandom_range(0, 99) < 28;
   endfunction

   // request driver
   always @(negedge clock) begin
      date_request_type r;
      if (!reset && (!req_if.valid || request_taken)) begin
         if (pending_requests.size() != 0 && !idle_now()) begin
            r = pending_requests.pop_front();
            req_if.cmd <= r.cmd;
            req_if.in_month <= r.in_month;
            req_if.in_day <= r.in_day;
            req_if.in_year <= r.in_year;
            req_if.julian_in <= r.julian_in;
            req_if.day_offset <= r.day_offset;
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (cycle_count == STALL_START) stall_left = STALL_CYCLES;
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !idle_now();
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      date_request_type  r;
      date_response_type e;
      request_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         cycle_count++;
         quiet_cycles++;
         if (req_if.valid && req_if.ready) begin
            r.cmd = req_if.cmd; r.in_month = req_if.in_month; r.in_day = req_if.in_day;
            r.in_year = req_if.in_year; r.julian_in = req_if.julian_in;
            r.day_offset = req_if.day_offset;
            expected_responses.push_back(predict_response(r));
            quiet_cycles = 0;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            quiet_cycles = 0;
            if (expected_responses.size() == 0) begin
               $error("unexpected response");
               errors++;
            end else begin
               e = expected_responses.pop_front();
               check_field("accepted", e.accepted, rsp_if.accepted);
               check_field("cur_month", e.cur_month, rsp_if.cur_month);
               check_field("cur_day", e.cur_day, rsp_if.cur_day);
               check_field("cur_year", e.cur_year, rsp_if.cur_year);
               check_field("julian_day", e.julian_day, rsp_if.julian_day);
               check_field("weekday", e.weekday, rsp_if.weekday);
               check_field("day_of_year", e.day_of_year, rsp_if.day_of_year);
               check_field("days_between", e.days_between, rsp_if.days_between);
            end
         end
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

endmodule
`default_nettype wire
